// ===== rtl/core/md5_pkg.sv =====
package md5_pkg;

   // Chaining value after reset and after each digest
   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam logic [7:0]  PAD_BYTE    = 8'h80;
   localparam logic [5:0]  LAST_POS    = 6'd63;
   localparam logic [5:0]  LEN_POS     = 6'd56;
   localparam logic [3:0]  LEN_LO_WORD = 4'd14;
   localparam logic [3:0]  LEN_HI_WORD = 4'd15;

   // Handshake between the sequencer and the compression core
   typedef struct packed {
      logic start;
      logic restart;
   } core_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_sts_type;

   // Round constants
   function automatic logic [31:0] md5_k(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   // Rotate amount, indexed by {round group, round[1:0]}
   function automatic logic [4:0] md5_rot(input logic [3:0] idx);
      logic [4:0] s;
      case (idx)
         4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
         4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // Message word used by a round
   function automatic logic [3:0] md5_g(input logic [5:0] idx);
      logic [3:0] t;
      logic [3:0] g;
      t = idx[3:0];
      case (idx[5:4])
         2'd0:    g = t;
         2'd1:    g = 4'(t * 4'd5 + 4'd1);
         2'd2:    g = 4'(t * 4'd3 + 4'd5);
         2'd3:    g = 4'(t * 4'd7);
         default: g = t;
      endcase
      return g;
   endfunction

endpackage

// ===== rtl/core/md5_req_if.sv =====
interface md5_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       message_end;

   modport source (output valid, data_byte, byte_valid, message_end, input ready);
   modport sink   (input valid, data_byte, byte_valid, message_end, output ready);
endinterface

// ===== rtl/core/md5_rsp_if.sv =====
interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_half;
   logic        half_index;
   logic        final_half;

   modport source (output valid, digest_half, half_index, final_half, input ready);
   modport sink   (input valid, digest_half, half_index, final_half, output ready);
endinterface

// ===== rtl/core/md5_buf.sv =====
module md5_buf (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [3:0]  wr_addr,
   input  logic [31:0] wr_data,
   input  logic [3:0]  rd_addr,
   output logic [31:0] rd_data_ff
);

   // 16-word message block, one write and one registered read per cycle
   logic [31:0] mem [16];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ===== rtl/core/md5_core.sv =====
module md5_core
   import md5_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  core_ctl_type ctl,
   output core_sts_type sts,
   output logic [3:0]   rd_addr,
   input  logic [31:0]  rd_data,
   output logic [127:0] chain
);

   typedef enum logic [2:0] {
      C_IDLE  = 3'b001,
      C_ROUND = 3'b010,
      C_FOLD  = 3'b100
   } core_state_type;

   core_state_type state_ff, state_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] a_in, b_in, c_in, d_in;
   logic [31:0] ha_ff, hb_ff, hc_ff, hd_ff;
   logic [31:0] ha_in, hb_in, hc_in, hd_in;
   logic [31:0] f;
   logic [31:0] sum;
   logic [63:0] rot_dbl;
   logic [4:0]  shamt;

   // Round function
   always_comb begin
      case (rnd_ff[5:4])
         2'd0:    f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1:    f = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2:    f = b_ff ^ c_ff ^ d_ff;
         2'd3:    f = c_ff ^ (b_ff | ~d_ff);
         default: f = b_ff;
      endcase
      shamt   = md5_rot({rnd_ff[5:4], rnd_ff[1:0]});
      sum     = a_ff + f + md5_k(rnd_ff) + rd_data;
      rot_dbl = {sum, sum} << shamt;
   end

   // Sequencing, working registers and chaining value
   always_comb begin
      state_in = state_ff;
      rnd_in   = 6'd0;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      ha_in    = ha_ff;
      hb_in    = hb_ff;
      hc_in    = hc_ff;
      hd_in    = hd_ff;
      case (state_ff)
         C_IDLE: begin
            if (ctl.restart) begin
               ha_in = INIT_A;
               hb_in = INIT_B;
               hc_in = INIT_C;
               hd_in = INIT_D;
            end else if (ctl.start) begin
               a_in     = ha_ff;
               b_in     = hb_ff;
               c_in     = hc_ff;
               d_in     = hd_ff;
               state_in = C_ROUND;
            end
         end
         C_ROUND: begin
            rnd_in = rnd_ff + 6'd1;
            a_in   = d_ff;
            b_in   = b_ff + rot_dbl[63:32];
            c_in   = b_ff;
            d_in   = c_ff;
            if (rnd_ff == LAST_POS) begin
               state_in = C_FOLD;
            end
         end
         C_FOLD: begin
            ha_in    = ha_ff + a_ff;
            hb_in    = hb_ff + b_ff;
            hc_in    = hc_ff + c_ff;
            hd_in    = hd_ff + d_ff;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   // Word for the next round is addressed from rnd_in, so the registered read has it ready as that round begins
   assign rd_addr  = md5_g(rnd_in);
   assign sts.busy = (state_ff != C_IDLE);
   assign sts.done = (state_ff == C_FOLD);
   assign chain    = {hd_ff, hc_ff, hb_ff, ha_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         rnd_ff   <= 6'd0;
         ha_ff    <= INIT_A;
         hb_ff    <= INIT_B;
         hc_ff    <= INIT_C;
         hd_ff    <= INIT_D;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         ha_ff    <= ha_in;
         hb_ff    <= hb_in;
         hc_ff    <= hc_in;
         hd_ff    <= hd_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
   end

endmodule

// ===== rtl/core/md5_digest.sv =====
// A byte item is taken only while the digest is idle; the 64th byte of a
// block adds a compression of 64 rounds on one shared round unit, each reading
// its word from the block memory ahead of the round, plus start and fold.
// A message end adds padding writes and one or two compressions,
// then the two digest halves follow on the result channel.
// Synchronous reset restores the initial chaining value and a zero length.
module md5_digest
   import md5_pkg::*;
(
   input logic       clock,
   input logic       reset,
   md5_req_if.sink   req_if,
   md5_rsp_if.source rsp_if
);

   typedef enum logic [8:0] {
      T_IDLE = 9'b000000001,
      T_CMP  = 9'b000000010,
      T_WAIT = 9'b000000100,
      T_PAD  = 9'b000001000,
      T_ZERO = 9'b000010000,
      T_LEN0 = 9'b000100000,
      T_LEN1 = 9'b001000000,
      T_OUT0 = 9'b010000000,
      T_OUT1 = 9'b100000000
   } top_state_type;

   top_state_type state_ff, state_in;
   logic [60:0]  count_ff, count_in;
   logic [31:0]  word_ff, word_in;
   logic         end_ff, end_in;
   logic         extra_ff, extra_in;
   logic         fin_ff, fin_in;
   logic [4:0]   zidx_ff, zidx_in;

   logic         wr_en;
   logic [3:0]   wr_addr;
   logic [31:0]  wr_data;
   logic [3:0]   rd_addr;
   logic [31:0]  rd_data;
   core_ctl_type ctl;
   core_sts_type sts;
   logic [127:0] chain;

   logic [5:0]   pos;
   logic [4:0]   sh;
   logic [4:0]   zlimit;
   logic         req_acc;

   assign pos     = count_ff[5:0];
   assign sh      = {pos[1:0], 3'b000};
   assign zlimit  = extra_ff ? 5'd15 : 5'd13;
   assign req_acc = req_if.valid & req_if.ready;

   md5_buf u_buf (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   md5_core u_core (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .sts     (sts),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .chain   (chain)
   );

   // Byte packing, padding sweep and result sequencing
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      word_in     = word_ff;
      end_in      = end_ff;
      extra_in    = extra_ff;
      fin_in      = fin_ff;
      zidx_in     = zidx_ff;
      wr_en       = 1'b0;
      wr_addr     = pos[5:2];
      wr_data     = word_ff;
      ctl.start   = 1'b0;
      ctl.restart = 1'b0;
      case (state_ff)
         T_IDLE: begin
            if (req_acc) begin
               if (req_if.byte_valid) begin
                  if (pos[1:0] == 2'd0) begin
                     word_in = {24'd0, req_if.data_byte};
                  end else begin
                     word_in = word_ff | ({24'd0, req_if.data_byte} << sh);
                  end
                  wr_en    = 1'b1;
                  wr_data  = word_in;
                  count_in = count_ff + 61'd1;
               end
               if (req_if.byte_valid && pos == LAST_POS) begin
                  end_in   = req_if.message_end;
                  state_in = T_CMP;
               end else if (req_if.message_end) begin
                  state_in = T_PAD;
               end
            end
         end
         T_PAD: begin
            // pad byte after the last message byte
            if (pos[1:0] == 2'd0) begin
               wr_data = {24'd0, PAD_BYTE};
            end else begin
               wr_data = word_ff | ({24'd0, PAD_BYTE} << sh);
            end
            wr_en    = 1'b1;
            zidx_in  = {1'b0, pos[5:2]} + 5'd1;
            extra_in = (pos >= LEN_POS);
            end_in   = 1'b0;
            state_in = T_ZERO;
         end
         T_ZERO: begin
            // zero fill, one word a cycle
            if (zidx_ff <= zlimit) begin
               wr_en   = 1'b1;
               wr_addr = zidx_ff[3:0];
               wr_data = 32'd0;
               zidx_in = zidx_ff + 5'd1;
            end else if (extra_ff) begin
               state_in = T_CMP;
            end else begin
               state_in = T_LEN0;
            end
         end
         T_LEN0: begin
            wr_en    = 1'b1;
            wr_addr  = LEN_LO_WORD;
            wr_data  = {count_ff[28:0], 3'b000};
            state_in = T_LEN1;
         end
         T_LEN1: begin
            wr_en    = 1'b1;
            wr_addr  = LEN_HI_WORD;
            wr_data  = count_ff[60:29];
            fin_in   = 1'b1;
            state_in = T_CMP;
         end
         T_CMP: begin
            ctl.start = 1'b1;
            state_in  = T_WAIT;
         end
         T_WAIT: begin
            if (sts.done) begin
               if (fin_ff) begin
                  state_in = T_OUT0;
               end else if (extra_ff) begin
                  // length did not fit: second block starts from word 0
                  extra_in = 1'b0;
                  zidx_in  = 5'd0;
                  state_in = T_ZERO;
               end else if (end_ff) begin
                  state_in = T_PAD;
               end else begin
                  state_in = T_IDLE;
               end
            end
         end
         T_OUT0: begin
            if (rsp_if.ready) begin
               state_in = T_OUT1;
            end
         end
         T_OUT1: begin
            if (rsp_if.ready) begin
               ctl.restart = 1'b1;
               count_in    = 61'd0;
               fin_in      = 1'b0;
               state_in    = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   assign req_if.ready = (state_ff == T_IDLE);

   // Results come straight from the registered chaining value
   assign rsp_if.valid       = (state_ff == T_OUT0) || (state_ff == T_OUT1);
   assign rsp_if.digest_half = (state_ff == T_OUT1) ? chain[127:64] : chain[63:0];
   assign rsp_if.half_index  = (state_ff == T_OUT1);
   assign rsp_if.final_half  = (state_ff == T_OUT1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         count_ff <= 61'd0;
         end_ff   <= 1'b0;
         extra_ff <= 1'b0;
         fin_ff   <= 1'b0;
         zidx_ff  <= 5'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         end_ff   <= end_in;
         extra_ff <= extra_in;
         fin_ff   <= fin_in;
         zidx_ff  <= zidx_in;
      end
      word_ff <= word_in;
   end

endmodule

// ===== test/md5_digest_tb.sv =====
module md5_digest_tb;

   localparam int CLK_HALF      = 6;
   localparam int RAND_ITEMS    = 450;
   localparam int MIN_MESSAGES  = 10;
   localparam int IDLE_LIMIT    = 4000;
   localparam int DRAIN_CYCLES  = 200;

   // Lengths around the padding boundaries (length field fits / spills over)
   localparam int unsigned EDGE_LENS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

   // Chaining value at the start of every message
   localparam logic [31:0] IV [4] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};

   // Per-round additive constants
   localparam logic [31:0] SINE_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Left-rotate amounts, indexed by {round group, step[1:0]}
   localparam int unsigned ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                            4, 11, 16, 23, 6, 10, 15, 21};

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       message_end;
   } byte_item_type;

   typedef struct packed {
      logic [63:0] digest_half;
      logic        half_index;
      logic        final_half;
   } digest_part_type;

   logic clock;
   logic reset;

   md5_req_if req_if ();
   md5_rsp_if rsp_if ();

   md5_digest i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Predictor state
   logic [31:0] chain_w [4];
   logic [31:0] block_w [16];
   logic [60:0] byte_count;

   byte_item_type   pending_items [$];
   digest_part_type expected_digests [$];

   byte_item_type cur_item;
   int unsigned burst_left;
   int unsigned gap_left;
   int unsigned n_errors;
   int unsigned n_queued;
   int unsigned n_queued_msgs;
   int unsigned n_taken;
   int unsigned n_bytes;
   int unsigned n_msgs;
   int unsigned n_checked;
   int unsigned idle_cycles;
   int unsigned ready_mode;
   int unsigned mode_timer;
   int unsigned stall_left;

   always #CLK_HALF clock = ~clock;

   // One 64-step compression of block_w into chain_w
   function automatic void md5_compress();
      logic [31:0] a, b, c, d, f, sum, tmp;
      int unsigned g, s, grp;
      a = chain_w[0];
      b = chain_w[1];
      c = chain_w[2];
      d = chain_w[3];
      for (int unsigned i = 0; i < 64; i++) begin
         grp = i / 16;
         case (grp)
            0: begin
               f = (b & c) | (~b & d);
               g = i;
            end
            1: begin
               f = (b & d) | (c & ~d);
               g = (5 * i + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * i + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * i) % 16;
            end
         endcase
         sum = a + f + SINE_K[i] + block_w[g];
         s   = ROT_AMT[grp * 4 + i % 4];
         tmp = d;
         d   = c;
         c   = b;
         b   = b + ((sum << s) | (sum >> (32 - s)));
         a   = tmp;
      end
      chain_w[0] += a;
      chain_w[1] += b;
      chain_w[2] += c;
      chain_w[3] += d;
   endfunction

   // Little-endian byte placement; byte 0 of a word clears the rest
   function automatic void place_byte(input logic [5:0] pos, input logic [7:0] val);
      if (pos[1:0] == 2'd0)
         block_w[pos[5:2]] = {24'd0, val};
      else
         block_w[pos[5:2]] |= 32'(val) << (8 * pos[1:0]);
   endfunction

   function automatic void restart_digest();
      for (int i = 0; i < 4; i++)
         chain_w[i] = IV[i];
      byte_count = '0;
   endfunction

   // Update the predictor with one accepted item; queue the digest on end
   function automatic void absorb_item(input byte_item_type it);
      logic [5:0]      pos;
      logic [63:0]     bit_len;
      digest_part_type part;
      int unsigned     w;
      if (it.byte_valid) begin
         pos = byte_count[5:0];
         place_byte(pos, it.data_byte);
         byte_count = byte_count + 61'd1;
         n_bytes++;
         if (pos == 6'd63)
            md5_compress();
      end
      if (it.message_end) begin
         pos = byte_count[5:0];
         place_byte(pos, 8'h80);
         for (w = pos[5:2] + 1; w < 16; w++)
            block_w[w] = '0;
         // length no longer fits: spill into an extra block
         if (pos >= 6'd56) begin
            md5_compress();
            for (w = 0; w < 16; w++)
               block_w[w] = '0;
         end
         bit_len = {byte_count, 3'b000};
         block_w[14] = bit_len[31:0];
         block_w[15] = bit_len[63:32];
         md5_compress();
         part.digest_half = {chain_w[1], chain_w[0]};
         part.half_index  = 1'b0;
         part.final_half  = 1'b0;
         expected_digests.push_back(part);
         part.digest_half = {chain_w[3], chain_w[2]};
         part.half_index  = 1'b1;
         part.final_half  = 1'b1;
         expected_digests.push_back(part);
         n_msgs++;
         restart_digest();
      end
   endfunction

   function automatic void queue_item(input logic [7:0] val, input logic bv, input logic me);
      byte_item_type it;
      it.data_byte   = val;
      it.byte_valid  = bv;
      it.message_end = me;
      pending_items.push_back(it);
      if (bv || me)
         n_queued++;
      if (me)
         n_queued_msgs++;
   endfunction

   // Random message content, sprinkled with idle items
   function automatic void queue_message(input int unsigned len, input bit end_on_byte);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 6)
            queue_item(8'($urandom), 1'b0, 1'b0);
         queue_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte || len == 0)
         queue_item(8'($urandom), 1'b0, 1'b1);
   endfunction

   // Request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            absorb_item(cur_item);
            n_taken++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0 || pending_items.size() == 0) begin
               if (gap_left > 0)
                  gap_left--;
               req_if.valid <= 1'b0;
            end else begin
               cur_item = pending_items.pop_front();
               req_if.valid       <= 1'b1;
               req_if.data_byte   <= cur_item.data_byte;
               req_if.byte_valid  <= cur_item.byte_valid;
               req_if.message_end <= cur_item.message_end;
               if (burst_left == 0)
                  burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 200)
                                                           : $urandom_range(1, 16);
               burst_left--;
               if (burst_left == 0)
                  gap_left = $urandom_range(1, 7);
            end
         end
      end
   end

   // Result sink: stall pattern switches between a few modes
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         ready_mode = 0;
         mode_timer = 0;
         stall_left = 0;
      end else begin
         if (mode_timer == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_timer = $urandom_range(20, 120);
         end
         mode_timer--;
         case (ready_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ~rsp_if.ready;
            2: rsp_if.ready <= ($urandom_range(0, 2) == 0);
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rsp_if.ready <= 1'b0;
               end else begin
                  stall_left = $urandom_range(1, 12);
                  rsp_if.ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // Result monitor: compare against the oldest expected digest half
   always @(posedge clock) begin
      digest_part_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_digests.size() == 0) begin
            $error("unexpected result: digest_half %h half_index %0d final_half %0d",
                   rsp_if.digest_half, rsp_if.half_index, rsp_if.final_half);
            n_errors++;
         end else begin
            want = expected_digests.pop_front();
            n_checked++;
            if (rsp_if.digest_half !== want.digest_half) begin
               $error("digest_half: expected %h, actual %h", want.digest_half,
                      rsp_if.digest_half);
               n_errors++;
            end
            if (rsp_if.half_index !== want.half_index) begin
               $error("half_index: expected %0d, actual %0d", want.half_index,
                      rsp_if.half_index);
               n_errors++;
            end
            if (rsp_if.final_half !== want.final_half) begin
               $error("final_half: expected %0d, actual %0d", want.final_half,
                      rsp_if.final_half);
               n_errors++;
            end
         end
      end
   end

   // Watchdog: too long without any item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("md5_digest_tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      int unsigned sel;
      int unsigned len;
      clock              = 1'b0;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.data_byte   = '0;
      req_if.byte_valid  = 1'b0;
      req_if.message_end = 1'b0;
      rsp_if.ready       = 1'b0;
      n_errors  = 0;
      n_queued  = 0;
      n_queued_msgs = 0;
      n_taken   = 0;
      n_bytes   = 0;
      n_msgs    = 0;
      n_checked = 0;
      idle_cycles = 0;
      for (int i = 0; i < 16; i++)
         block_w[i] = '0;
      restart_digest();

      // Directed: empty message, idle item, byte with end, end without byte
      queue_item(8'h00, 1'b0, 1'b1);
      queue_item(8'hff, 1'b0, 1'b0);
      queue_item(8'hff, 1'b1, 1'b1);
      queue_item(8'h00, 1'b1, 1'b0);
      queue_item(8'h5a, 1'b0, 1'b0);
      queue_item(8'hff, 1'b0, 1'b1);
      // "abc", ending on its last byte
      queue_item(8'h61, 1'b1, 1'b0);
      queue_item(8'h62, 1'b1, 1'b0);
      queue_item(8'h63, 1'b1, 1'b1);
      // alternating bit patterns, then a separate end item
      queue_item(8'hff, 1'b1, 1'b0);
      queue_item(8'h00, 1'b1, 1'b0);
      queue_item(8'haa, 1'b1, 1'b0);
      queue_item(8'h55, 1'b1, 1'b0);
      queue_item(8'ha5, 1'b0, 1'b1);

      // Random messages: mostly short, some on padding boundaries, some longer
      while (n_queued < RAND_ITEMS || n_queued_msgs < MIN_MESSAGES) begin
         sel = $urandom_range(0, 99);
         if (sel < 65)
            len = $urandom_range(0, 12);
         else if (sel < 85)
            len = EDGE_LENS[$urandom_range(0, 9)];
         else
            len = $urandom_range(13, 80);
         if ($urandom_range(0, 9) == 0)
            queue_item(8'($urandom), 1'b0, 1'b0);
         queue_message(len, $urandom_range(0, 1));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Drain: all items sent and every digest half seen
      @(negedge clock);
      while (pending_items.size() > 0 || req_if.valid || expected_digests.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_digests.size() > 0) begin
         $error("%0d expected digest halves never arrived", expected_digests.size());
         n_errors++;
      end

      $display("Hashed %0d messages (%0d request items, %0d data bytes), %0d halves checked.",
               n_msgs, n_taken, n_bytes, n_checked);
      $display("Included empty and pad-boundary lengths, idle items, source gaps, sink stalls.");
      if (n_errors == 0)
         $display("md5_digest_tb: PASS");
      else
         $display("md5_digest_tb: FAIL");
      $finish;
   end

endmodule
